@@ rtl/pfa_pkg.sv @@
// Shared types and constants for the physical frame allocator.
// No dependencies; used by pfa_region, pfa_stack and the top level.
package pfa_pkg;

  localparam int FRAME_W   = 52;          // frame number width
  localparam int PTR_W     = FRAME_W + 1; // bump pointer with room for end + 1
  localparam int ADDR_W    = 64;          // byte address width
  localparam int CFG_IDX_W = 4;           // config index width, upper codes ignored
  localparam int NUM_SLOTS = 2;           // storage slots for regions and exclusions

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R0_START = 4'd0,
    CFG_R0_END   = 4'd1,
    CFG_R1_START = 4'd2,
    CFG_R1_END   = 4'd3,
    CFG_X0_START = 4'd4,
    CFG_X0_END   = 4'd5,
    CFG_X1_START = 4'd6,
    CFG_X1_END   = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_OOM        = 2'd1,
    STATUS_BAD_ADDR   = 2'd2,
    STATUS_STACK_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_LOAD,
    SR_EXCL,
    SR_CHECK
  } srch_state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_POP,
    T_DONE
  } top_state_e;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [FRAME_W-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } srch_rsp_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [FRAME_W-1:0] frame;
  } stk_req_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [FRAME_W-1:0] rd_data;
  } stk_rsp_t;

  // frame 0 is never handed out, so a start of 0 begins at frame 1
  function automatic logic [FRAME_W-1:0] start_ptr(input logic [FRAME_W-1:0] v);
    start_ptr = (v == '0) ? FRAME_W'(1) : v;
  endfunction

endpackage

@@ rtl/pfa_region.sv @@
// Region and exclusion config registers, bump pointers and the region search sequencer.
// Depends on pfa_pkg.
module pfa_region #(
  parameter int REGIONS  = 2,
  parameter int EXCLUDES = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfa_pkg::cfg_wr_t    cfg_i,
  input  logic                start_i,
  output pfa_pkg::srch_rsp_t  rsp_o
);
  import pfa_pkg::*;

  logic [FRAME_W-1:0] rstart_q [NUM_SLOTS];
  logic [FRAME_W-1:0] rend_q   [NUM_SLOTS];
  logic [FRAME_W-1:0] xstart_q [NUM_SLOTS];
  logic [FRAME_W-1:0] xend_q   [NUM_SLOTS];
  logic [FRAME_W-1:0] nf_q     [NUM_SLOTS];

  srch_state_e        state_q, state_d;
  logic [0:0]         r_q, r_d;
  logic [0:0]         e_q, e_d;
  logic [PTR_W-1:0]   p_q, p_d;

  logic               nf_we;
  logic [FRAME_W-1:0] nf_wdata;

  logic [FRAME_W-1:0] cur_nf, cur_start, cur_end;
  logic               ex_hit, at_end, reg_full, last_r, last_e;
  logic [PTR_W-1:0]   ex_cand;

  assign cur_nf    = nf_q[r_q];
  assign cur_start = rstart_q[r_q];
  assign cur_end   = rend_q[r_q];
  assign reg_full  = (cur_nf == cur_end);
  assign ex_hit    = !((cur_start > xend_q[e_q]) || (cur_end < xstart_q[e_q]));
  assign ex_cand   = {1'b0, xend_q[e_q]} + PTR_W'(1);
  assign at_end    = (p_q >= {1'b0, cur_end});
  assign last_r    = (r_q == 1'(REGIONS - 1));
  assign last_e    = (e_q == 1'(EXCLUDES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rstart_q[i] <= '0;
        rend_q[i]   <= '0;
        xstart_q[i] <= '1;
        xend_q[i]   <= '1;
        nf_q[i]     <= FRAME_W'(1);
      end
    end else begin
      if (nf_we) begin
        nf_q[r_q] <= nf_wdata;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_R0_START: begin
            rstart_q[0] <= cfg_i.data;
            nf_q[0]     <= start_ptr(cfg_i.data);
          end
          CFG_R0_END:   rend_q[0]   <= cfg_i.data;
          CFG_R1_START: begin
            rstart_q[1] <= cfg_i.data;
            nf_q[1]     <= start_ptr(cfg_i.data);
          end
          CFG_R1_END:   rend_q[1]   <= cfg_i.data;
          CFG_X0_START: xstart_q[0] <= cfg_i.data;
          CFG_X0_END:   xend_q[0]   <= cfg_i.data;
          CFG_X1_START: xstart_q[1] <= cfg_i.data;
          CFG_X1_END:   xend_q[1]   <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      r_q     <= '0;
      e_q     <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      e_q     <= e_d;
      p_q     <= p_d;
    end
  end

  // next state: one region load, one exclusion per cycle, then the end check
  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    e_d     = e_q;
    p_d     = p_q;
    case (state_q)
      SR_IDLE: begin
        if (start_i) begin
          r_d     = '0;
          state_d = SR_LOAD;
        end
      end
      SR_LOAD: begin
        if (reg_full) begin
          if (last_r) begin
            state_d = SR_IDLE;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          p_d     = {1'b0, cur_nf};
          e_d     = '0;
          state_d = SR_EXCL;
        end
      end
      SR_EXCL: begin
        if (ex_hit && (ex_cand > p_q)) begin
          p_d = ex_cand;
        end
        if (last_e) begin
          state_d = SR_CHECK;
        end else begin
          e_d = e_q + 1'b1;
        end
      end
      SR_CHECK: begin
        if (at_end && !last_r) begin
          r_d     = r_q + 1'b1;
          state_d = SR_LOAD;
        end else begin
          state_d = SR_IDLE;
        end
      end
      default: state_d = SR_IDLE;
    endcase
  end

  always_comb begin
    rsp_o    = '0;
    nf_we    = 1'b0;
    nf_wdata = cur_end;
    case (state_q)
      SR_LOAD: begin
        if (reg_full && last_r) begin
          rsp_o.done = 1'b1;
        end
      end
      SR_CHECK: begin
        nf_we = 1'b1;
        if (at_end) begin
          // clamp the pointer to the end; region yields nothing
          nf_wdata   = cur_end;
          rsp_o.done = last_r;
        end else begin
          nf_wdata    = p_q[FRAME_W-1:0] + FRAME_W'(1);
          rsp_o.done  = 1'b1;
          rsp_o.hit   = 1'b1;
          rsp_o.frame = p_q[FRAME_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/pfa_stack.sv @@
// LIFO free stack: synchronous frame memory with registered read and a fill count.
// Depends on pfa_pkg.
module pfa_stack #(
  parameter int FREE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfa_pkg::stk_req_t req_i,
  output pfa_pkg::stk_rsp_t rsp_o
);
  import pfa_pkg::*;

  localparam int IDX_W = $clog2(FREE_DEPTH);
  localparam int CNT_W = $clog2(FREE_DEPTH + 1);

  logic [FRAME_W-1:0] mem [FREE_DEPTH];
  logic [FRAME_W-1:0] rd_data_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   count_dec;

  assign count_dec = count_q - CNT_W'(1);

  always_comb begin
    count_d = count_q;
    if (req_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (req_i.pop) begin
      count_d = count_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // push writes the slot above the top, pop reads the top; never in the same cycle
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[count_q[IDX_W-1:0]] <= req_i.frame;
    end
    if (req_i.pop) begin
      rd_data_q <= mem[count_dec[IDX_W-1:0]];
    end
  end

  assign rsp_o.empty   = (count_q == '0);
  assign rsp_o.full    = (count_q == CNT_W'(FREE_DEPTH));
  assign rsp_o.rd_data = rd_data_q;

endmodule

@@ rtl/physical_frame_allocator_top.sv @@
// Physical frame allocator top level: request sequencing and the output register.
// Depends on pfa_pkg, pfa_region and pfa_stack.
//
//   channel  handshake              word
//   in       in_valid_i/in_stall_o  action_i, free_address_i
//   out      out_valid_o/out_stall_i frame_address_o, status_o
//   cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time. Free: checked on accept, result registered.
// Allocate: per region searched a load, one step per exclusion and an end check
// (a full region: the load only), one exclusion per cycle in the sequencer; a stack
// pop adds a step for the registered memory read. Reset loads the config defaults,
// sets both pointers to frame 1 and clears the stack count.
// A stalled result stays in the output register while the next request is taken.
module physical_frame_allocator_top #(
  parameter int FRAME_BYTES = 4096,
  parameter int FREE_DEPTH  = 1024,
  parameter int REGIONS     = 2,
  parameter int EXCLUDES    = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [pfa_pkg::ADDR_W-1:0]        free_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pfa_pkg::ADDR_W-1:0]        frame_address_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfa_pkg::FRAME_W-1:0]       cfg_data_i
);
  import pfa_pkg::*;

  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

  top_state_e         state_q, state_d;
  logic [FRAME_W-1:0] res_frame_q, res_frame_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  status_e            out_status_q, out_status_d;

  cfg_wr_t            cfg_wr;
  srch_rsp_t          srch_rsp;
  stk_req_t           stk_req;
  stk_rsp_t           stk_rsp;
  logic               srch_start;

  logic               in_acc, out_free;
  logic               free_bad;
  logic [FRAME_W-1:0] free_frame;
  logic [ADDR_W-1:0]  res_wide;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  pfa_region #(
    .REGIONS  (REGIONS),
    .EXCLUDES (EXCLUDES)
  ) u_region (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_wr),
    .start_i (srch_start),
    .rsp_o   (srch_rsp)
  );

  pfa_stack #(
    .FREE_DEPTH (FREE_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stk_req),
    .rsp_o  (stk_rsp)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // zero, misaligned, or a frame number beyond the frame width
  assign free_bad = (free_address_i == '0)
                 || (free_address_i[FRAME_SHIFT-1:0] != '0)
                 || ((free_address_i >> (FRAME_SHIFT + FRAME_W)) != '0);
  assign free_frame = FRAME_W'(free_address_i >> FRAME_SHIFT);

  assign res_wide = {{(ADDR_W - FRAME_W){1'b0}}, res_frame_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          state_d = action_i ? T_DONE : T_SEARCH;
        end
      end
      T_SEARCH: begin
        if (srch_rsp.done) begin
          state_d = (srch_rsp.hit || stk_rsp.empty) ? T_DONE : T_POP;
        end
      end
      T_POP:  state_d = T_DONE;
      T_DONE: begin
        if (out_free) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != T_IDLE);
    srch_start    = 1'b0;
    stk_req       = '0;
    stk_req.frame = free_frame;
    res_frame_d   = res_frame_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_addr_d    = out_addr_q;
    out_status_d  = out_status_q;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          res_frame_d = '0;
          if (action_i) begin
            if (free_bad) begin
              res_status_d = STATUS_BAD_ADDR;
            end else if (stk_rsp.full) begin
              res_status_d = STATUS_STACK_FULL;
            end else begin
              res_status_d = STATUS_OK;
              stk_req.push = 1'b1;
            end
          end else begin
            srch_start = 1'b1;
          end
        end
      end
      T_SEARCH: begin
        if (srch_rsp.done) begin
          if (srch_rsp.hit) begin
            res_frame_d  = srch_rsp.frame;
            res_status_d = STATUS_OK;
          end else if (stk_rsp.empty) begin
            res_frame_d  = '0;
            res_status_d = STATUS_OOM;
          end else begin
            stk_req.pop = 1'b1;
          end
        end
      end
      T_POP: begin
        res_frame_d  = stk_rsp.rd_data;
        res_status_d = STATUS_OK;
      end
      T_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_wide << FRAME_SHIFT;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_addr_q;
  assign status_o        = out_status_q;

endmodule
